/* hw/rtl/pss_pkg.sv */
// Shared types and constants for the pressure sensor compensation pipeline.
// No dependencies; every other file of the block but pss_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

  // Calibration coefficients unpacked from the four calibration words.
  typedef struct packed {
    logic [14:0] c1;
    logic [11:0] c2;
    logic [9:0]  c3;
    logic [9:0]  c4;
    logic [10:0] c5;
    logic [5:0]  c6;
  } coef_t;

  // First-order results handed to the second-order stages.
  typedef struct packed {
    logic signed [13:0] temp1;
    logic signed [18:0] p1;
    logic [24:0]        dsq;
    logic               lo;
    logic               hi;
  } mid_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CAL_ONE   = 2'd0;
  localparam logic [1:0] REG_CAL_TWO   = 2'd1;
  localparam logic [1:0] REG_CAL_THREE = 2'd2;
  localparam logic [1:0] REG_CAL_FOUR  = 2'd3;

  localparam int UT1_OFFSET    = 20224;
  localparam int SENS_C6_OFS   = 50;
  localparam int OFF_REF       = 512;
  localparam int SENS_OFFSET   = 24576;
  localparam int D1_OFFSET     = 7168;
  localparam int P_OFFSET      = 2500;
  localparam int TEMP_REF      = 200;
  localparam int TEMP_HIGH     = 400;
  localparam int TEMP_HIGH_REF = 450;
  localparam int T2_C6_OFS     = 24;
  localparam int P_LO_REF      = 3500;
  localparam int P_HI_REF      = 10000;

  localparam int TEMP_MIN  = -32768;
  localparam int TEMP_MAX  = 32767;
  localparam int PRESS_MIN = -65536;
  localparam int PRESS_MAX = 65535;

endpackage

`default_nettype wire

/* hw/rtl/pss_regs.sv */
// Calibration register file on an APB-style port and coefficient unpacking.
// Depends on pss_pkg for coef_t and the register indexes.
`timescale 1ns / 1ps
`default_nettype none

module pss_regs
  import pss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output coef_t            coef
);

  logic [15:0] w1;
  logic [15:0] w2;
  logic [15:0] w3;
  logic [15:0] w4;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      w1 <= '0;
      w2 <= '0;
      w3 <= '0;
      w4 <= '0;
    end else if (wr) begin
      case (idx)
        REG_CAL_ONE:   w1 <= pwdata[15:0];
        REG_CAL_TWO:   w2 <= pwdata[15:0];
        REG_CAL_THREE: w3 <= pwdata[15:0];
        REG_CAL_FOUR:  w4 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAL_ONE:   prdata = {16'd0, w1};
      REG_CAL_TWO:   prdata = {16'd0, w2};
      REG_CAL_THREE: prdata = {16'd0, w3};
      REG_CAL_FOUR:  prdata = {16'd0, w4};
      default:       prdata = '0;
    endcase
  end

  assign coef.c1 = w1[15:1];
  assign coef.c2 = {w3[5:0], w4[5:0]};
  assign coef.c3 = w4[15:6];
  assign coef.c4 = w3[15:6];
  assign coef.c5 = {w1[0], w2[15:6]};
  assign coef.c6 = w2[5:0];

endmodule

`default_nettype wire

/* hw/rtl/pss_first.sv */
// First-order compensation: five pipeline stages from raw counts to the
// first-order temperature and pressure. Depends on pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pss_first
  import pss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  coef_t            coef,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] d1,
  input  wire logic [15:0] d2,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mid_t             out_data
);

  logic [4:0] vld;
  logic [4:0] en;

  // A stage takes new data when it is empty or the next one moves on.
  always_comb begin
    en[4] = !vld[4] || out_ready;
    for (int i = 3; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < 5; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 1: offsets of the raw counts.
  logic [15:0]        ut1;
  logic signed [16:0] dt;
  logic signed [16:0] dd1;
  logic signed [16:0] s1_dt;
  logic signed [16:0] s1_dd1;

  assign ut1 = 16'({coef.c5, 3'b000}) + 16'(UT1_OFFSET);
  assign dt  = $signed({1'b0, d2}) - $signed({1'b0, ut1});
  assign dd1 = $signed({1'b0, d1}) - 17'(D1_OFFSET);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_dt  <= dt;
      s1_dd1 <= dd1;
    end
  end

  // Stage 2: the three products with the temperature difference.
  logic [6:0]         c6p50;
  logic signed [10:0] c4m;
  logic signed [23:0] s2_mt;
  logic signed [25:0] s2_mo;
  logic signed [26:0] s2_ms;
  logic signed [16:0] s2_dd1;

  assign c6p50 = {1'b0, coef.c6} + 7'(SENS_C6_OFS);
  assign c4m   = $signed({1'b0, coef.c4}) - 11'(OFF_REF);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_mt  <= 24'(s1_dt) * 24'($signed({1'b0, c6p50}));
      s2_mo  <= 26'(c4m) * 26'(s1_dt);
      s2_ms  <= 27'($signed({1'b0, coef.c3})) * 27'(s1_dt);
      s2_dd1 <= s1_dd1;
    end
  end

  // Stage 3: first-order temperature, offset and sensitivity.
  logic signed [13:0] s3_temp1;
  logic signed [15:0] s3_off;
  logic signed [17:0] s3_sens;
  logic signed [16:0] s3_dd1;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_temp1 <= 14'(s2_mt >>> 10) + 14'(TEMP_REF);
      s3_off   <= $signed({2'b00, coef.c2, 2'b00}) + 16'(s2_mo >>> 12);
      s3_sens  <= $signed({3'b000, coef.c1}) + 18'(s2_ms >>> 10) + 18'(SENS_OFFSET);
      s3_dd1   <= s2_dd1;
    end
  end

  // Stage 4: sensitivity times pressure count; pick the correction band.
  logic               lo;
  logic               hi;
  logic signed [13:0] d;
  logic signed [33:0] s4_prod;
  logic signed [15:0] s4_off;
  logic signed [13:0] s4_temp1;
  logic signed [13:0] s4_d;
  logic               s4_lo;
  logic               s4_hi;

  assign lo = s3_temp1 < 14'(TEMP_REF);
  assign hi = s3_temp1 > 14'(TEMP_HIGH);
  assign d  = lo ? 14'(TEMP_REF) - s3_temp1 : 14'(TEMP_HIGH_REF) - s3_temp1;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_prod  <= 34'(s3_sens) * 34'(s3_dd1);
      s4_off   <= s3_off;
      s4_temp1 <= s3_temp1;
      s4_d     <= d;
      s4_lo    <= lo;
      s4_hi    <= hi;
    end
  end

  // Stage 5: first-order pressure and the squared band distance.
  logic signed [20:0] x;
  logic signed [24:0] x10;
  logic signed [25:0] dsq;

  assign x   = 21'(s4_prod >>> 14) - 21'(s4_off);
  assign x10 = (25'(x) <<< 3) + (25'(x) <<< 1);
  assign dsq = 26'(s4_d) * 26'(s4_d);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      out_data.temp1 <= s4_temp1;
      out_data.p1    <= 19'(x10 >>> 5) + 19'(P_OFFSET);
      out_data.dsq   <= dsq[24:0];
      out_data.lo    <= s4_lo;
      out_data.hi    <= s4_hi;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pss_second.sv */
// Second-order correction and saturation: three pipeline stages, the last
// of which is the output register. Depends on pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pss_second
  import pss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  coef_t       coef,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  mid_t        in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic signed [15:0] temperature_tenths,
  output logic signed [16:0] pressure_tenths
);

  logic [2:0] vld;
  logic [2:0] en;

  always_comb begin
    en[2] = !vld[2] || out_ready;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // Stage 6: band gain times squared distance. Outside both bands the gain
  // is zero, so the whole correction comes out zero.
  logic [6:0]         c6p24;
  logic [9:0]         k11;
  logic [8:0]         k3;
  logic [9:0]         k;
  logic signed [19:0] pd;
  logic [33:0]        s6_kx;
  logic signed [19:0] s6_pd;
  logic signed [13:0] s6_temp1;
  logic signed [18:0] s6_p1;
  logic               s6_lo;

  assign c6p24 = {1'b0, coef.c6} + 7'(T2_C6_OFS);
  assign k11   = {c6p24, 3'b000} + 10'({c6p24, 1'b0}) + 10'(c6p24);
  assign k3    = {c6p24, 1'b0} + 9'(c6p24);
  assign k     = in_data.lo ? k11 : (in_data.hi ? 10'(k3) : '0);
  assign pd    = in_data.lo ? 20'(in_data.p1) - 20'(P_LO_REF)
                            : 20'(in_data.p1) - 20'(P_HI_REF);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s6_kx    <= 34'(k) * 34'(in_data.dsq);
      s6_pd    <= pd;
      s6_temp1 <= in_data.temp1;
      s6_p1    <= in_data.p1;
      s6_lo    <= in_data.lo;
    end
  end

  // Stage 7: temperature correction and its product with the pressure.
  logic [13:0]        t2;
  logic [15:0]        m;
  logic signed [36:0] s7_prod2;
  logic [13:0]        s7_t2;
  logic signed [13:0] s7_temp1;
  logic signed [18:0] s7_p1;
  logic               s7_lo;

  assign t2 = s6_kx[33:20];
  assign m  = s6_lo ? 16'({t2, 1'b0}) + 16'(t2) : 16'(t2);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s7_prod2 <= 37'($signed({1'b0, m})) * 37'(s6_pd);
      s7_t2    <= t2;
      s7_temp1 <= s6_temp1;
      s7_p1    <= s6_p1;
      s7_lo    <= s6_lo;
    end
  end

  // Stage 8: apply both corrections and saturate into the output register.
  logic signed [23:0] p2;
  logic signed [16:0] tf;
  logic signed [24:0] pf;
  logic signed [15:0] tsat;
  logic signed [16:0] psat;

  assign p2 = s7_lo ? 24'(s7_prod2 >>> 14) : 24'(s7_prod2 >>> 13);
  assign tf = 17'(s7_temp1) - $signed({3'b000, s7_t2});
  assign pf = 25'(s7_p1) - 25'(p2);

  always_comb begin
    if (tf < 17'(TEMP_MIN)) begin
      tsat = 16'(TEMP_MIN);
    end else if (tf > 17'(TEMP_MAX)) begin
      tsat = 16'(TEMP_MAX);
    end else begin
      tsat = 16'(tf);
    end
    if (pf < 25'(PRESS_MIN)) begin
      psat = 17'(PRESS_MIN);
    end else if (pf > 25'(PRESS_MAX)) begin
      psat = 17'(PRESS_MAX);
    end else begin
      psat = 17'(pf);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      temperature_tenths <= tsat;
      pressure_tenths    <= psat;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pressure_sensor_compensation_top.sv */
// Top level of the pressure sensor compensation block.
// Instantiates pss_regs, pss_first and pss_second; uses pss_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one beat of raw pressure and temperature counts per clock
// while the output side does not stall, and returns one beat with the
// compensated temperature (0.1 C) and pressure (0.1 mbar), both saturated.
// It is an eight-stage pipeline, and a new beat can be taken in every cycle
// in which the output side does not stall. When the output side stalls, only
// the stages that hold data stop; empty stages keep filling. The user must
// write calibration words over the APB port only while no beat is in
// flight; the block itself does not enforce this.
module pressure_sensor_compensation_top
  import pss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // raw_pressure [15:0], raw_temperature [31:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // temperature_tenths [15:0], pressure_tenths [32:16]
);

  coef_t              coef;
  mid_t               mid;
  logic               mid_valid;
  logic               mid_ready;
  logic signed [15:0] temperature_tenths;
  logic signed [16:0] pressure_tenths;

  pss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  pss_first u_first (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .d1        (s_tdata[15:0]),
    .d2        (s_tdata[31:16]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid)
  );

  pss_second u_second (
    .clk                (clk),
    .rst                (rst),
    .coef               (coef),
    .in_valid           (mid_valid),
    .in_ready           (mid_ready),
    .in_data            (mid),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .temperature_tenths (temperature_tenths),
    .pressure_tenths    (pressure_tenths)
  );

  assign m_tdata = {7'd0, pressure_tenths, temperature_tenths};

endmodule

`default_nettype wire

/* hw/rtl/pss_checker.sv */
// Port-level checks for the pressure sensor compensation block, bound to
// the top level. Sees only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module pss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        pready,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // A stalled output beat stays put with the same data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // With no beat waiting at the output every stage can move, so input is open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  // The corrections only lower the temperature, which tops out at 520.0 C,
  // and the padding bits stay clear.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[15:0]) <= 16'sd5200 && m_tdata[39:33] == 7'd0)
    else $error("output temperature or padding out of range");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind pressure_sensor_compensation_top pss_checker u_pss_checker (
  .clk      (clk),
  .rst      (rst),
  .pready   (pready),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
